/* hw/rtl/pafe_pkg.sv */
package pafe_pkg;

  // The sine is sampled at this many points per turn; it must be a power of two.
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int SINE_IDX_BITS    = $clog2(SINE_TABLE_DEPTH);
  localparam int PH_SHIFT         = 16 - SINE_IDX_BITS;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int ENV_W      = 26;
  localparam int WAVE_W     = 18;
  localparam int S_W        = 21;
  localparam int SIN_STAGES = 4;

  // Odd polynomial for a quarter turn, Q16, evaluated from the highest term down.
  localparam logic signed [S_W-1:0] SIN_LEAD = S_W'(11);
  localparam logic signed [S_W-1:0] SIN_COEF [SIN_STAGES] = '{
    S_W'(-307), S_W'(5223), S_W'(-42334), S_W'(102944)
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_TIMING  = 3'd0,
    REG_OUT_TIMING = 3'd1,
    REG_IN_VALUE   = 3'd2,
    REG_BASE_VALUE = 3'd3,
    REG_RISE_RATE  = 3'd4,
    REG_FALL_RATE  = 3'd5,
    REG_WAVE_FREQ  = 3'd6,
    REG_WAVE_AMP   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic        [16:0] in_timing;
    logic        [16:0] out_timing;
    logic        [16:0] in_value;
    logic        [16:0] base_value;
    logic signed [23:0] rise_rate;
    logic signed [23:0] fall_rate;
    logic        [16:0] wave_freq;
    logic        [16:0] wave_amp;
  } cfg_t;

  typedef struct packed {
    logic                    valid;
    logic signed [ENV_W-1:0] env;
    logic        [15:0]      theta_mag;
    logic                    theta_neg;
  } front_t;

  typedef struct packed {
    logic                     valid;
    logic signed [ENV_W-1:0]  env;
    logic signed [WAVE_W-1:0] wave;
  } wave_t;

endpackage

/* hw/rtl/pafe_front.sv */
module pafe_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_take,
  input  logic [16:0]      in_life_fraction,
  input  logic [15:0]      in_age_frames,
  input  logic [16:0]      in_wave_random,
  input  pafe_pkg::cfg_t   cfg,
  output pafe_pkg::front_t front
);
  import pafe_pkg::*;

  logic                    rise;
  logic                    fall;
  logic        [16:0]      x_sel;
  logic signed [23:0]      rate_sel;
  logic        [16:0]      base_sel;
  logic signed [41:0]      s1_prod_nxt;

  logic                    s1_valid_r;
  logic signed [41:0]      s1_prod_r;
  logic        [16:0]      s1_base_r;
  logic        [32:0]      s1_ra_r;

  logic signed [17:0]      freq_term;
  logic        [16:0]      freq_mag;
  logic        [49:0]      mag_prod;
  logic signed [ENV_W-1:0] env_nxt;

  logic                    fr_valid_r;
  logic signed [ENV_W-1:0] fr_env_r;
  logic        [15:0]      fr_mag_r;
  logic                    fr_neg_r;

  // Stage one: pick the envelope segment and form the slope product.
  always_comb begin
    rise = in_life_fraction < cfg.in_timing;
    fall = in_life_fraction > cfg.out_timing;
    if (rise) begin
      rate_sel = cfg.rise_rate;
      x_sel    = in_life_fraction;
      base_sel = cfg.in_value;
    end else if (fall) begin
      rate_sel = cfg.fall_rate;
      x_sel    = in_life_fraction - cfg.out_timing;
      base_sel = cfg.base_value;
    end else begin
      rate_sel = '0;
      x_sel    = '0;
      base_sel = cfg.base_value;
    end
    s1_prod_nxt = rate_sel * $signed({1'b0, x_sel});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    s1_prod_r <= s1_prod_nxt;
    s1_base_r <= base_sel;
    s1_ra_r   <= in_wave_random * in_age_frames;
  end

  // Stage two: envelope sum and the phase magnitude. Only the bits that survive
  // the shift by eighteen and the wrap to sixteen bits are kept.
  always_comb begin
    freq_term = 18'sd65536 - $signed({1'b0, cfg.wave_freq});
    freq_mag  = freq_term[17] ? 17'(-freq_term) : freq_term[16:0];
    mag_prod  = s1_ra_r * freq_mag;
    env_nxt   = $signed({9'b0, s1_base_r}) + $signed(s1_prod_r[41:16]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    fr_env_r <= env_nxt;
    fr_mag_r <= mag_prod[33:18];
    fr_neg_r <= freq_term[17];
  end

  assign front = '{valid: fr_valid_r, env: fr_env_r, theta_mag: fr_mag_r,
                   theta_neg: fr_neg_r};

endmodule

/* hw/rtl/pafe_sine.sv */
module pafe_sine (
  input  logic             clk,
  input  logic             rst_n,
  input  pafe_pkg::front_t front,
  output pafe_pkg::wave_t  wave
);
  import pafe_pkg::*;

  function automatic logic signed [S_W-1:0] horner_step(
    input logic signed [S_W-1:0] coef,
    input logic signed [S_W-1:0] acc,
    input logic        [16:0]    mul
  );
    logic signed [S_W+17:0] prod;
    logic signed [S_W+1:0]  sum;
    prod = acc * $signed({1'b0, mul});
    sum  = $signed(prod[S_W+17:16]) + $signed({{2{coef[S_W-1]}}, coef});
    return sum[S_W-1:0];
  endfunction

  logic [15:0]             theta;
  logic [15:0]             phase;
  logic [13:0]             ph_rem;
  logic [14:0]             quarter_x;
  logic [33:0]             u_sq;

  logic                    u_valid_r;
  logic [16:0]             u_r;
  logic                    u_neg_r;
  logic signed [ENV_W-1:0] u_env_r;

  logic                    p_valid_r [SIN_STAGES+1];
  logic signed [S_W-1:0]   p_s_r     [SIN_STAGES+1];
  logic [16:0]             p_u2_r    [SIN_STAGES+1];
  logic [16:0]             p_u_r     [SIN_STAGES+1];
  logic                    p_neg_r   [SIN_STAGES+1];
  logic signed [ENV_W-1:0] p_env_r   [SIN_STAGES+1];

  logic signed [S_W-1:0]   sin_raw;
  logic [16:0]             sin_mag;
  logic signed [WAVE_W-1:0] wave_nxt;

  logic                     w_valid_r;
  logic signed [ENV_W-1:0]  w_env_r;
  logic signed [WAVE_W-1:0] w_wave_r;

  // Angle to sample phase, then fold into the first quarter.
  always_comb begin
    theta     = front.theta_neg ? 16'(-front.theta_mag) : front.theta_mag;
    phase     = (theta >> PH_SHIFT) << PH_SHIFT;
    ph_rem    = phase[13:0];
    quarter_x = phase[14] ? 15'(15'd16384 - {1'b0, ph_rem}) : {1'b0, ph_rem};
    u_sq      = u_r * u_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_valid_r <= 1'b0;
    end else begin
      u_valid_r <= front.valid;
    end
  end

  always_ff @(posedge clk) begin
    u_r     <= {quarter_x, 2'b00};
    u_neg_r <= phase[15];
    u_env_r <= front.env;
  end

  // Entry zero holds the squared phase; entries one onwards are Horner steps.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= SIN_STAGES; k++) begin
        p_valid_r[k] <= 1'b0;
      end
    end else begin
      p_valid_r[0] <= u_valid_r;
      for (int k = 1; k <= SIN_STAGES; k++) begin
        p_valid_r[k] <= p_valid_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    p_s_r[0]   <= SIN_LEAD;
    p_u2_r[0]  <= u_sq[32:16];
    p_u_r[0]   <= u_r;
    p_neg_r[0] <= u_neg_r;
    p_env_r[0] <= u_env_r;
    for (int k = 1; k <= SIN_STAGES; k++) begin
      p_s_r[k]   <= horner_step(SIN_COEF[k-1], p_s_r[k-1], p_u2_r[k-1]);
      p_u2_r[k]  <= p_u2_r[k-1];
      p_u_r[k]   <= p_u_r[k-1];
      p_neg_r[k] <= p_neg_r[k-1];
      p_env_r[k] <= p_env_r[k-1];
    end
  end

  always_comb begin
    sin_raw = horner_step('0, p_s_r[SIN_STAGES], p_u_r[SIN_STAGES]);
    if (sin_raw[S_W-1]) begin
      sin_mag = '0;
    end else if (sin_raw > S_W'(65536)) begin
      sin_mag = 17'd65536;
    end else begin
      sin_mag = sin_raw[16:0];
    end
    wave_nxt = p_neg_r[SIN_STAGES] ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_valid_r <= 1'b0;
    end else begin
      w_valid_r <= p_valid_r[SIN_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    w_env_r  <= p_env_r[SIN_STAGES];
    w_wave_r <= wave_nxt;
  end

  assign wave = '{valid: w_valid_r, env: w_env_r, wave: w_wave_r};

  a_u_range: assert property (@(posedge clk) disable iff (!rst_n)
    u_valid_r |-> (u_r <= 17'd65536))
    else $error("folded phase beyond a quarter turn");

  a_wave_range: assert property (@(posedge clk) disable iff (!rst_n)
    w_valid_r |-> ((w_wave_r <= 65536) && (w_wave_r >= -65536)))
    else $error("sine sample outside unit range");

endmodule

/* hw/rtl/pafe_mix.sv */
module pafe_mix (
  input  logic            clk,
  input  logic            rst_n,
  input  pafe_pkg::wave_t wave,
  input  logic [16:0]     wave_amp,
  output logic            out_valid,
  output logic [7:0]      out_alpha_byte
);
  import pafe_pkg::*;

  logic signed [18:0]      wave_off;
  logic signed [36:0]      fprod_nxt;
  logic signed [19:0]      factor_nxt;
  logic signed [45:0]      vf_nxt;
  logic signed [53:0]      scaled;
  logic [21:0]             scaled_hi;
  logic [7:0]              alpha_nxt;

  logic                    f_valid_r;
  logic signed [ENV_W-1:0] f_env_r;
  logic signed [36:0]      f_prod_r;

  logic                    g_valid_r;
  logic signed [ENV_W-1:0] g_env_r;
  logic signed [19:0]      g_factor_r;

  logic                    m_valid_r;
  logic signed [45:0]      m_vf_r;

  logic                    out_valid_r;
  logic [7:0]              out_alpha_r;

  always_comb begin
    wave_off   = $signed({wave.wave[WAVE_W-1], wave.wave}) - 19'sd65536;
    fprod_nxt  = $signed({1'b0, wave_amp}) * wave_off;
    factor_nxt = 20'sd65536 + $signed(f_prod_r[36:17]);
    vf_nxt     = g_env_r * g_factor_r;
    // Times 255 as a shift and a subtract.
    scaled     = $signed({m_vf_r, 8'b0}) - $signed({{8{m_vf_r[45]}}, m_vf_r});
    scaled_hi  = scaled[53:32];
    if (scaled[53] || (scaled == '0)) begin
      alpha_nxt = '0;
    end else if (scaled_hi > 22'd255) begin
      alpha_nxt = 8'd255;
    end else begin
      alpha_nxt = scaled_hi[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r   <= 1'b0;
      g_valid_r   <= 1'b0;
      m_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      f_valid_r   <= wave.valid;
      g_valid_r   <= f_valid_r;
      m_valid_r   <= g_valid_r;
      out_valid_r <= m_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    f_env_r     <= wave.env;
    f_prod_r    <= fprod_nxt;
    g_env_r     <= f_env_r;
    g_factor_r  <= factor_nxt;
    m_vf_r      <= vf_nxt;
    out_alpha_r <= alpha_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_alpha_byte = out_alpha_r;

  a_mix_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(wave.valid, 4))
    else $error("result strobe without a sine sample four cycles earlier");

endmodule

/* hw/rtl/particle_alpha_flicker_envelope_core.sv */
// Alpha envelope with sine flicker, fully pipelined over thirteen register stages.
// Throughput: one item per clock; start is taken in every cycle and busy stays low.
// The out_valid strobe marks the taken item once it has passed every register stage;
// the depth is set by the chain of multipliers in the sine polynomial and scaling.
// The result receiver cannot stall, so each result is shown for exactly one cycle.
// Synchronous reset clears the pipeline valid bits and loads the register defaults.
module particle_alpha_flicker_envelope_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [16:0] in_life_fraction,
  input  logic [15:0] in_age_frames,
  input  logic [16:0] in_wave_random,
  output logic        out_valid,
  output logic [7:0]  out_alpha_byte,
  input  logic        cfg_we,
  input  logic [pafe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pafe_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pafe_pkg::*;

  cfg_t   cfg_r;
  cfg_t   cfg_nxt;
  front_t front;
  wave_t  wave;
  logic   in_take;

  assign busy    = 1'b0;
  assign in_take = start && !busy;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IN_TIMING:  cfg_nxt.in_timing  = cfg_wdata[16:0];
        REG_OUT_TIMING: cfg_nxt.out_timing = cfg_wdata[16:0];
        REG_IN_VALUE:   cfg_nxt.in_value   = cfg_wdata[16:0];
        REG_BASE_VALUE: cfg_nxt.base_value = cfg_wdata[16:0];
        REG_RISE_RATE:  cfg_nxt.rise_rate  = $signed(cfg_wdata);
        REG_FALL_RATE:  cfg_nxt.fall_rate  = $signed(cfg_wdata);
        REG_WAVE_FREQ:  cfg_nxt.wave_freq  = cfg_wdata[16:0];
        REG_WAVE_AMP:   cfg_nxt.wave_amp   = cfg_wdata[16:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{in_timing: 17'd0, out_timing: 17'd65536, in_value: 17'd65536,
                 base_value: 17'd65536, rise_rate: 24'sd65536, fall_rate: 24'sd65536,
                 wave_freq: 17'd0, wave_amp: 17'd0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pafe_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_take          (in_take),
    .in_life_fraction (in_life_fraction),
    .in_age_frames    (in_age_frames),
    .in_wave_random   (in_wave_random),
    .cfg              (cfg_r),
    .front            (front)
  );

  pafe_sine u_sine (
    .clk   (clk),
    .rst_n (rst_n),
    .front (front),
    .wave  (wave)
  );

  pafe_mix u_mix (
    .clk            (clk),
    .rst_n          (rst_n),
    .wave           (wave),
    .wave_amp       (cfg_r.wave_amp),
    .out_valid      (out_valid),
    .out_alpha_byte (out_alpha_byte)
  );

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_take, 13))
    else $error("result strobe without an item taken thirteen cycles earlier");

  a_front_follows: assert property (@(posedge clk) disable iff (!rst_n)
    front.valid |-> $past(in_take, 2))
    else $error("front stage valid without a matching item");

endmodule
